/* design/fccm_pkg.sv */
`default_nettype none
package fccm_pkg;

  localparam int DEF_CLUSTERS = 4096;
  localparam int CLUSTER_W    = 12;
  localparam int COUNT_OUT_W  = 13;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_LINK  = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] TAG_UNUSED   = 2'd0;
  localparam logic [1:0] TAG_RESERVED = 2'd1;
  localparam logic [1:0] TAG_LAST     = 2'd2;
  localparam logic [1:0] TAG_LINKED   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;

  typedef struct packed {
    logic [1:0]           mode;
    logic [CLUSTER_W-1:0] cluster;
    logic [CLUSTER_W-1:0] next_cluster;
    logic                 mark_last;
  } req_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0]   result_cluster;
    logic [1:0]             result_tag;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] free_count;
    logic [COUNT_OUT_W-1:0] freed_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd;
    logic alloc_take;
    logic step_ptr;
    logic link_wr;
    logic read_res;
    logic walk_free;
    logic walk_ok;
    logic walk_next;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       none_free;
    logic       ptr_oor;
    logic [1:0] rd_tag;
    logic       clr_last;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

/* design/fccm_ctrl.sv */
`default_nettype none
module fccm_ctrl
  import fccm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_RD    = 6'b001000,
    S_CHK   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        // out-of-range pointer or full table answers with the defaults set at load
        if (sts.mode == MODE_ALLOC) begin
          state_next = sts.none_free ? S_FIN : S_RD;
        end else begin
          state_next = sts.ptr_oor ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        unique case (sts.mode)
          MODE_ALLOC: begin
            if (sts.rd_tag == TAG_UNUSED) begin
              cmd.alloc_take = 1'b1;
              state_next     = S_FIN;
            end else begin
              cmd.step_ptr = 1'b1;
              state_next   = S_RD;
            end
          end
          MODE_LINK: begin
            cmd.link_wr = 1'b1;
            state_next  = S_FIN;
          end
          MODE_FREE: begin
            case (sts.rd_tag) inside
              TAG_UNUSED, TAG_RESERVED: begin
                state_next = S_FIN;
              end
              TAG_LAST: begin
                cmd.walk_free = 1'b1;
                cmd.walk_ok   = 1'b1;
                state_next    = S_FIN;
              end
              default: begin
                cmd.walk_free = 1'b1;
                cmd.walk_next = 1'b1;
                state_next    = S_START;
              end
            endcase
          end
          default: begin
            cmd.read_res = 1'b1;
            state_next   = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/fccm_dp.sv */
`default_nettype none
module fccm_dp
  import fccm_pkg::*;
#(
  parameter int CLUSTERS = DEF_CLUSTERS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int AW = $clog2(CLUSTERS);
  localparam int PW = (AW > CLUSTER_W) ? AW : CLUSTER_W;
  localparam int CW = $clog2(CLUSTERS + 1);
  localparam int EW = 2 + CLUSTER_W;

  logic [EW-1:0] mem [CLUSTERS];
  logic [EW-1:0] rdata;

  logic [AW-1:0]        clr_ptr;
  logic [PW-1:0]        ptr;
  logic [CW-1:0]        unused;
  logic [CW-1:0]        hint;
  logic [CW-1:0]        freed;
  logic [1:0]           req_mode;
  logic                 req_last;
  logic [CLUSTER_W-1:0] res_cluster;
  logic [1:0]           res_tag;
  logic [1:0]           res_status;

  logic [1:0]           rd_tag;
  logic [CLUSTER_W-1:0] rd_next;
  logic [1:0]           alloc_tag;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  assign rd_tag    = rdata[EW-1 -: 2];
  assign rd_next   = rdata[CLUSTER_W-1:0];
  assign alloc_tag = req_last ? TAG_LAST : TAG_RESERVED;

  always_comb begin
    wr_en   = cmd.clr_wr | cmd.alloc_take | cmd.link_wr | cmd.walk_free;
    wr_addr = cmd.clr_wr ? clr_ptr : ptr[AW-1:0];
    wr_data = '0;
    if (cmd.alloc_take) wr_data = {alloc_tag, {CLUSTER_W{1'b0}}};
    if (cmd.link_wr)    wr_data = {res_tag, res_cluster};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rdata <= mem[ptr[AW-1:0]];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      unused  <= CW'(CLUSTERS);
      hint    <= '0;
    end else begin
      if (cmd.clr_wr) clr_ptr <= clr_ptr + AW'(1);
      if (cmd.alloc_take) begin
        unused <= unused - CW'(1);
        hint   <= CW'(ptr) + CW'(1);
      end
      if (cmd.link_wr && rd_tag == TAG_UNUSED && unused != '0) begin
        unused <= unused - CW'(1);
      end
      if (cmd.walk_free) begin
        unused <= unused + CW'(1);
        if (CW'(ptr) < hint) hint <= CW'(ptr);
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= req.mode;
      req_last <= req.mark_last;
      ptr      <= (req.mode == MODE_ALLOC) ? PW'(hint) : PW'(req.cluster);
      freed    <= '0;
      res_cluster <= (req.mode == MODE_LINK && !req.mark_last) ? req.next_cluster : '0;
      if (req.mode == MODE_LINK) begin
        res_tag <= req.mark_last ? TAG_LAST : TAG_LINKED;
      end else begin
        res_tag <= TAG_UNUSED;
      end
      if (req.mode == MODE_FREE) begin
        res_status <= ST_BROKEN;
      end else if (req.mode == MODE_ALLOC && unused == '0) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_OK;
      end
    end
    if (cmd.step_ptr) ptr <= ptr + PW'(1);
    if (cmd.walk_next) ptr <= PW'(rd_next);
    if (cmd.alloc_take) begin
      res_cluster <= ptr[CLUSTER_W-1:0];
      res_tag     <= alloc_tag;
    end
    if (cmd.read_res) begin
      res_tag     <= rd_tag;
      res_cluster <= (rd_tag == TAG_LINKED) ? rd_next : '0;
    end
    if (cmd.walk_free) freed <= freed + CW'(1);
    if (cmd.walk_ok) res_status <= ST_OK;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.result_cluster <= res_cluster;
      rsp.result_tag     <= res_tag;
      rsp.status         <= res_status;
      rsp.free_count     <= COUNT_OUT_W'(unused);
      rsp.freed_count    <= COUNT_OUT_W'(freed);
    end
  end

  always_comb begin
    sts.mode      = req_mode;
    sts.none_free = (unused == '0);
    sts.ptr_oor   = ({1'b0, ptr} >= (PW + 1)'(CLUSTERS));
    sts.rd_tag    = rd_tag;
    sts.clr_last  = (clr_ptr == AW'(CLUSTERS - 1));
    sts.out_busy  = rsp_valid & ~rsp_ready;
  end

endmodule
`default_nettype wire

/* design/fat_cluster_chain_manager.sv */
// Cluster chain manager for a file-allocation table.
// Requests enter on req/req_valid/req_ready, one beat per request; each request
// returns exactly one beat on rsp/rsp_valid/rsp_ready. Modes: allocate the
// lowest unused cluster, link or mark an entry last, free a chain, read one entry.
// One request is worked on at a time, all table accesses through one memory port.
// Out-of-range read or link, and allocate on a full table, answer without a
// table access; read reads the entry, link reads and then writes it; allocate
// reads entries upward from the lowest-free hint until it finds an unused one;
// free walks the chain, freeing each entry, and stops on a last entry (status ok),
// at an out-of-range pointer or at an unused or reserved entry (status broken).
// req_ready returns in the same cycle that rsp_valid rises. The hint follows
// each allocation up and drops back on a free.
// After reset the table is cleared one entry a cycle, every entry in turn, with
// req_ready low; the free count starts at CLUSTERS.
// A finished result waits in an output register; the next request is accepted
// while it waits, and that request finishes only once the register is taken.
// rsp holds steady while rsp_valid is high and rsp_ready is low.
`default_nettype none
module fat_cluster_chain_manager
  import fccm_pkg::*;
#(
  parameter int CLUSTERS = DEF_CLUSTERS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  fccm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fccm_dp #(
    .CLUSTERS (CLUSTERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
